// ----- hw/rtl/valid_pixel_boundary_detect_top_macros.svh -----
`ifndef VALID_PIXEL_BOUNDARY_DETECT_TOP_MACROS_SVH
`define VALID_PIXEL_BOUNDARY_DETECT_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define VPBD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define VPBD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/vpbd_pkg.sv -----
`default_nettype none

package vpbd_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int SIZE_W  = 12;
    localparam int DEPTH_W = 16;
    localparam int COUNT_W = 23;

    localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};
    localparam logic [8:0]         NEIGH_MASK = 9'h1EF;

    localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(512);
    localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(424);

    localparam logic [0:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [0:0] REG_FRAME_HEIGHT = 1'b1;

    // Pixel in flight between the counter stage and the window stage.
    typedef struct packed {
        logic             cur;
        logic             frame_start;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             interior;
        logic             done;
        logic             has_result;
    } vpbd_item_t;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] hi);
        logic [SIZE_W-1:0] res;
        if (v < SIZE_W'(3))
            res = SIZE_W'(3);
        else if (v > hi)
            res = hi;
        else
            res = v;
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/vpbd_line_store.sv -----
`default_nettype none
`include "valid_pixel_boundary_detect_top_macros.svh"

module vpbd_line_store (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     rd_en,
    input  wire logic [vpbd_pkg::COL_W-1:0] rd_addr,
    input  wire logic                     wr_en,
    input  wire logic [vpbd_pkg::COL_W-1:0] wr_addr,
    input  wire logic                     wr_up,
    input  wire logic                     wr_mid,
    output logic                          up,
    output logic                          mid
);
    import vpbd_pkg::*;

    logic store_up  [MAX_WIDTH];
    logic store_mid [MAX_WIDTH];

    logic up_q, mid_q;
    logic fwd_reg, fwd_up_reg, fwd_mid_reg;
    logic fwd_next;

    assign fwd_next = wr_en && (wr_addr == rd_addr);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_up[wr_addr]  <= wr_up;
            store_mid[wr_addr] <= wr_mid;
        end
        if (rd_en)
        begin
            up_q        <= store_up[rd_addr];
            mid_q       <= store_mid[rd_addr];
            fwd_up_reg  <= wr_up;
            fwd_mid_reg <= wr_mid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fwd_reg <= 1'b0;
        else if (rd_en)
            fwd_reg <= fwd_next;
    end

    // Take the write in flight when it hits the entry being read.
    assign up  = fwd_reg ? fwd_up_reg  : up_q;
    assign mid = fwd_reg ? fwd_mid_reg : mid_q;

    `VPBD_ASSERT_NEXT(a_fwd_capture, rd_en && wr_en && (wr_addr == rd_addr), fwd_reg, "collision not forwarded")
    `VPBD_ASSERT_NEXT(a_fwd_clear, rd_en && !wr_en, !fwd_reg, "stale forward flag")
    `VPBD_ASSERT_NEXT(a_fwd_hold, !rd_en, $stable(fwd_reg), "forward flag moved without a read")

endmodule

`default_nettype wire

// ----- hw/rtl/vpbd_window.sv -----
`default_nettype none

module vpbd_window (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         fire,
    input  wire vpbd_pkg::vpbd_item_t         item,
    input  wire logic                         up,
    input  wire logic                         mid,
    input  wire logic                         out_ready,
    output logic                              out_valid,
    output logic                              edge_mark,
    output logic [vpbd_pkg::COL_W-1:0]        pixel_col,
    output logic [vpbd_pkg::ROW_W-1:0]        pixel_row,
    output logic [vpbd_pkg::COUNT_W-1:0]      edge_count,
    output logic                              frame_done
);
    import vpbd_pkg::*;

    logic [8:0]         win_reg, win_next;
    logic [COUNT_W-1:0] total_reg, total_next, base;
    logic               mark;
    logic               valid_reg;

    // Oldest column sits in the low bits; new column is {cur, mid, up}.
    assign win_next = {item.cur, mid, up, win_reg[8:3]};
    assign mark     = item.has_result && item.interior && win_next[4]
                      && ((win_next & NEIGH_MASK) != NEIGH_MASK);
    assign base     = item.frame_start ? '0 : total_reg;
    assign total_next = (mark && (base != COUNT_MAX)) ? base + COUNT_W'(1) : base;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg   <= '0;
            total_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                win_reg   <= win_next;
                total_reg <= total_next;
            end
            if (fire && item.has_result)
                valid_reg <= 1'b1;
            else if (out_ready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && item.has_result)
        begin
            edge_mark  <= mark;
            pixel_col  <= item.col - COL_W'(1);
            pixel_row  <= item.row - ROW_W'(1);
            edge_count <= total_next;
            frame_done <= item.done;
        end
    end

    assign out_valid = valid_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/valid_pixel_boundary_detect_top.sv -----
// Channel  | Handshake                   | Payload
// s_axis   | s_axis_tvalid/s_axis_tready | tdata: depth; tuser: frame_start
// m_axis   | m_axis_tvalid/m_axis_tready | tdata: mark, col, row, count; tlast: frame_done
// cfg      | cfg_we                      | cfg_index, cfg_data
//
// One pixel per cycle unless the output stalls, set by the single read-modify-write
// per pixel on the line stores. A pixel is read from the stores when it is accepted;
// when the window stage fires, it is written back and its result is registered.
// Reset clears counters, window and edge count and loads the 512 x 424 default size;
// stores need no clearing.
// A stalled output holds one result while one more pixel waits in the window stage.
`default_nettype none
`include "valid_pixel_boundary_detect_top_macros.svh"

module valid_pixel_boundary_detect_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [vpbd_pkg::DEPTH_W-1:0]  s_axis_tdata,  // [15:0] depth
    input  wire logic                          s_axis_tuser,  // [0] frame_start
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [47:0]                        m_axis_tdata,
    // [0] edge_mark, [11:1] pixel_col, [22:12] pixel_row, [45:23] edge_count, [47:46] zero
    output logic                               m_axis_tlast,  // frame_done
    input  wire logic                          cfg_we,
    input  wire logic [0:0]                    cfg_index,
    input  wire logic [vpbd_pkg::SIZE_W-1:0]   cfg_data
);
    import vpbd_pkg::*;

    logic [SIZE_W-1:0] width_reg, height_reg;
    logic [SIZE_W-1:0] w_eff, h_eff, w_m1, h_m1;

    logic [COL_W-1:0] col_reg, col_next, c0;
    logic [ROW_W-1:0] row_reg, row_next, r0;
    logic             col_end, row_end;

    vpbd_item_t item_reg, item_next;
    logic       s1_valid_reg;
    logic       s1_fire, accept, out_free;

    logic       st_up, st_mid;

    logic                mark;
    logic [COL_W-1:0]    pcol;
    logic [ROW_W-1:0]    prow;
    logic [COUNT_W-1:0]  pcount;

    assign w_eff = clamp_size(width_reg, SIZE_W'(MAX_WIDTH));
    assign h_eff = clamp_size(height_reg, SIZE_W'(MAX_HEIGHT));
    assign w_m1  = w_eff - SIZE_W'(1);
    assign h_m1  = h_eff - SIZE_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: height_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Handshake: window stage fires unless its result would overwrite a waiting one.
    assign out_free      = !m_axis_tvalid || m_axis_tready;
    assign s1_fire       = s1_valid_reg && (out_free || !item_reg.has_result);
    assign s_axis_tready = !s1_valid_reg || s1_fire;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Position of the incoming pixel.
    assign c0      = s_axis_tuser ? '0 : col_reg;
    assign r0      = s_axis_tuser ? '0 : row_reg;
    assign col_end = {1'b0, c0} >= w_m1;
    assign row_end = {1'b0, r0} >= h_m1;

    always_comb
    begin
        if (col_end)
        begin
            col_next = '0;
            row_next = row_end ? '0 : r0 + ROW_W'(1);
        end
        else
        begin
            col_next = c0 + COL_W'(1);
            row_next = r0;
        end
    end

    always_comb
    begin
        item_next.cur         = s_axis_tdata != '0;
        item_next.frame_start = s_axis_tuser;
        item_next.col         = c0;
        item_next.row         = r0;
        item_next.done        = col_end && row_end;
        item_next.has_result  = (c0 != '0) && (r0 != '0);
        // Reported pixel (c0-1, r0-1) lies strictly inside the frame.
        item_next.interior    = (c0 >= COL_W'(2)) && (r0 >= ROW_W'(2))
                                && ({1'b0, c0} <= w_m1) && ({1'b0, r0} <= h_m1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (s1_fire)
                s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= item_next;
    end

    vpbd_line_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (c0),
        .wr_en   (s1_fire),
        .wr_addr (item_reg.col),
        .wr_up   (st_mid),
        .wr_mid  (item_reg.cur),
        .up      (st_up),
        .mid     (st_mid)
    );

    vpbd_window u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (s1_fire),
        .item       (item_reg),
        .up         (st_up),
        .mid        (st_mid),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .edge_mark  (mark),
        .pixel_col  (pcol),
        .pixel_row  (prow),
        .edge_count (pcount),
        .frame_done (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, pcount, prow, pcol, mark};

    `VPBD_ASSERT_NOW(a_no_result_never_blocks, s1_valid_reg && !item_reg.has_result, s1_fire, "empty item stalled")
    `VPBD_ASSERT_NOW(a_ready_when_empty, !s1_valid_reg, s_axis_tready, "ready low with empty stage")
    `VPBD_ASSERT_NOW(a_mark_counted, m_axis_tvalid && mark, pcount != '0, "edge with zero count")

endmodule

`default_nettype wire

// ----- dv/valid_pixel_boundary_detect_top_tb.sv -----
`timescale 1ns / 100ps

module valid_pixel_boundary_detect_top_tb;

    import vpbd_pkg::*;

    typedef struct packed {
        logic               mark;
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
        logic [COUNT_W-1:0] count;
        logic               done;
    } boundary_result_t;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic               frame_start;
        logic               typed;
        boundary_result_t   want;
    } directed_step_t;

    localparam boundary_result_t NO_MARK = '0;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [DEPTH_W-1:0]  s_axis_tdata = '0;   // [15:0] depth
    logic                s_axis_tuser = 1'b0; // [0] frame_start
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [47:0]         m_axis_tdata;
    // [0] edge_mark, [11:1] pixel_col, [22:12] pixel_row, [45:23] edge_count
    logic                m_axis_tlast;        // [0] frame_done
    logic                cfg_we = 1'b0;
    logic [0:0]          cfg_index = REG_FRAME_WIDTH;
    logic [SIZE_W-1:0]   cfg_data = '0;

    // Predictor state
    logic [SIZE_W-1:0]   width_reg = SIZE_W'(512);
    logic [SIZE_W-1:0]   height_reg = SIZE_W'(424);
    bit                  upper_valid [MAX_WIDTH];
    bit                  middle_valid [MAX_WIDTH];
    logic [8:0]          valid_window = '0;
    int                  next_col = 0;
    int                  next_row = 0;
    int                  edge_total = 0;

    boundary_result_t    expected_marks [$];
    int                  mismatches = 0;
    bit                  no_stall = 1'b0;
    int                  random_items;
    int                  frames;
    logic [SIZE_W-1:0]   w_raw;
    logic [SIZE_W-1:0]   h_raw;

    // Two 3x3 frames: the first opens with a zero corner, the second runs on
    // without frame_start and ends on a zero, so its count carries over.
    directed_step_t directed_steps [18] = '{
        '{16'h0000, 1'b1, 1'b0, NO_MARK},
        '{16'hFFFF, 1'b0, 1'b0, NO_MARK},
        '{16'h0001, 1'b0, 1'b0, NO_MARK},
        '{16'h8000, 1'b0, 1'b0, NO_MARK},
        '{16'hAAAA, 1'b0, 1'b1, '{1'b0, 11'd0, 11'd0, 23'd0, 1'b0}},
        '{16'h5555, 1'b0, 1'b1, '{1'b0, 11'd1, 11'd0, 23'd0, 1'b0}},
        '{16'h00FF, 1'b0, 1'b0, NO_MARK},
        '{16'hFF00, 1'b0, 1'b1, '{1'b0, 11'd0, 11'd1, 23'd0, 1'b0}},
        '{16'h7FFF, 1'b0, 1'b1, '{1'b1, 11'd1, 11'd1, 23'd1, 1'b1}},
        '{16'h1234, 1'b0, 1'b0, NO_MARK},
        '{16'hEDCB, 1'b0, 1'b0, NO_MARK},
        '{16'h0F0F, 1'b0, 1'b0, NO_MARK},
        '{16'hF0F0, 1'b0, 1'b0, NO_MARK},
        '{16'h3C3C, 1'b0, 1'b1, '{1'b0, 11'd0, 11'd0, 23'd1, 1'b0}},
        '{16'hC3C3, 1'b0, 1'b1, '{1'b0, 11'd1, 11'd0, 23'd1, 1'b0}},
        '{16'h6996, 1'b0, 1'b0, NO_MARK},
        '{16'h9669, 1'b0, 1'b1, '{1'b0, 11'd0, 11'd1, 23'd1, 1'b0}},
        '{16'h0000, 1'b0, 1'b1, '{1'b1, 11'd1, 11'd1, 23'd2, 1'b1}}
    };

    valid_pixel_boundary_detect_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int effective_size(input logic [SIZE_W-1:0] raw, input int hi);
        if (raw < SIZE_W'(3))
            return 3;
        if (int'(raw) > hi)
            return hi;
        return int'(raw);
    endfunction

    function automatic logic [DEPTH_W-1:0] random_depth(input int zero_pct);
        int pick;
        pick = $urandom_range(9);
        if ($urandom_range(99) < zero_pct)
            return '0;
        if (pick == 0)
            return '1;
        if (pick == 1)
            return DEPTH_W'(1);
        return DEPTH_W'($urandom_range(65535, 1));
    endfunction

    task automatic predict_boundary(input logic [DEPTH_W-1:0] depth, input logic fs,
                                    output bit has_result, output boundary_result_t res);
        int w;
        int h;
        int c;
        int r;
        logic cur;
        logic up;
        logic mid;
        w = effective_size(width_reg, MAX_WIDTH);
        h = effective_size(height_reg, MAX_HEIGHT);
        cur = (depth != '0);
        up = 1'b0;
        mid = 1'b0;
        res = '0;
        has_result = 1'b0;
        if (fs)
        begin
            next_col = 0;
            next_row = 0;
            edge_total = 0;
        end
        c = next_col;
        r = next_row;
        if (c < MAX_WIDTH)
        begin
            up = upper_valid[c];
            mid = middle_valid[c];
            upper_valid[c] = mid;
            middle_valid[c] = cur;
        end
        // newest column enters at the top, oldest drops out at the bottom
        valid_window = {cur, mid, up, valid_window[8:3]};
        res.done = (c >= w - 1) && (r >= h - 1);
        if (c >= w - 1)
        begin
            next_col = 0;
            next_row = (r >= h - 1) ? 0 : r + 1;
        end
        else
            next_col = c + 1;
        if (c >= 1 && r >= 1)
        begin
            has_result = 1'b1;
            if (c - 1 >= 1 && r - 1 >= 1 && c - 1 <= w - 2 && r - 1 <= h - 2 &&
                valid_window[4] && (valid_window & NEIGH_MASK) != NEIGH_MASK)
            begin
                res.mark = 1'b1;
                if (edge_total < int'(COUNT_MAX))
                    edge_total++;
            end
            res.col = COL_W'(c - 1);
            res.row = ROW_W'(r - 1);
            res.count = COUNT_W'(edge_total);
        end
    endtask

    // Called at a rising edge; returns at the rising edge that takes the item,
    // or later if the sender idles.
    task automatic send_pixel(input logic [DEPTH_W-1:0] depth, input logic fs,
                              input bit use_typed, input boundary_result_t typed_result);
        bit hit;
        boundary_result_t res;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= depth;
        s_axis_tuser <= fs;
        do
            @(negedge clk);
        while (!s_axis_tready);
        predict_boundary(depth, fs, hit, res);
        if (use_typed)
            expected_marks.push_back(typed_result);
        else if (hit)
            expected_marks.push_back(res);
        @(posedge clk);
        if (!no_stall && $urandom_range(99) < 15)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < 15);
        end
    endtask

    // Hold input until every result is out and the pipeline has emptied.
    task automatic settle_outputs;
        s_axis_tvalid <= 1'b0;
        while (expected_marks.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_sizes(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
        cfg_we <= 1'b1;
        cfg_index <= REG_FRAME_WIDTH;
        cfg_data <= w;
        @(posedge clk);
        cfg_index <= REG_FRAME_HEIGHT;
        cfg_data <= h;
        @(posedge clk);
        cfg_we <= 1'b0;
        width_reg = w;
        height_reg = h;
    endtask

    task automatic send_frame(input bit with_start);
        int zero_pct;
        int pixels;
        logic fs;
        zero_pct = ($urandom_range(3) == 0) ? 90 : 2 + 24 * $urandom_range(2);
        pixels = effective_size(width_reg, MAX_WIDTH) * effective_size(height_reg, MAX_HEIGHT);
        for (int i = 0; i < pixels; i++)
        begin
            // a rare stray frame_start restarts the frame mid-way
            fs = (i == 0 && with_start) || ($urandom_range(499) == 0);
            send_pixel(random_depth(zero_pct), fs, 1'b0, NO_MARK);
        end
    endtask

    function automatic void compare_field(input string name, input longint unsigned want,
                                          input longint unsigned got);
        if (want != got)
        begin
            mismatches++;
            if (mismatches <= 200)
                $error("%s: expected %0d, got %0d", name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin
        m_axis_tready <= no_stall || ($urandom_range(99) >= 15);
    end

    // Sample before the edge so the item seen is the one taken at that edge.
    always @(negedge clk)
    begin
        boundary_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_marks.size() == 0)
            begin
                mismatches++;
                $error("result item at col %0d row %0d with none expected",
                       m_axis_tdata[11:1], m_axis_tdata[22:12]);
            end
            else
            begin
                want = expected_marks.pop_front();
                compare_field("edge_mark", want.mark, m_axis_tdata[0]);
                compare_field("pixel_col", want.col, m_axis_tdata[11:1]);
                compare_field("pixel_row", want.row, m_axis_tdata[22:12]);
                compare_field("edge_count", want.count, m_axis_tdata[45:23]);
                compare_field("frame_done", want.done, m_axis_tlast);
            end
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // reset frame size, a little past one row; the first item carries no frame_start
        for (int i = 0; i < 540; i++)
            send_pixel(random_depth(30), 1'b0, 1'b0, NO_MARK);
        settle_outputs();

        // sizes below the minimum act as 3x3
        write_sizes(SIZE_W'(0), SIZE_W'(1));
        foreach (directed_steps[i])
            send_pixel(directed_steps[i].depth, directed_steps[i].frame_start,
                       directed_steps[i].typed, directed_steps[i].want);
        settle_outputs();

        random_items = 0;
        while (random_items < 150)
        begin
            w_raw = ($urandom_range(5) == 0) ? SIZE_W'($urandom_range(2))
                                             : SIZE_W'($urandom_range(40, 3));
            h_raw = ($urandom_range(5) == 0) ? SIZE_W'($urandom_range(2))
                                             : SIZE_W'($urandom_range(12, 3));
            write_sizes(w_raw, h_raw);
            frames = $urandom_range(3, 1);
            for (int f = 0; f < frames; f++)
            begin
                send_frame(f == 0 || $urandom_range(3) != 0);
                random_items += effective_size(width_reg, MAX_WIDTH) *
                                effective_size(height_reg, MAX_HEIGHT);
            end
            settle_outputs();
        end

        // oversized width clamps to the widest row; first part of a frame only
        write_sizes(SIZE_W'(4095), SIZE_W'(3));
        for (int i = 0; i < 150; i++)
            send_pixel(random_depth(30), i == 0, 1'b0, NO_MARK);
        settle_outputs();

        // tallest frame, top rows only, no idling on either side
        write_sizes(SIZE_W'(3), SIZE_W'(2048));
        no_stall <= 1'b1;
        for (int i = 0; i < 240; i++)
            send_pixel(random_depth(30), i == 0, 1'b0, NO_MARK);
        settle_outputs();
        no_stall <= 1'b0;

        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/vpbd_pkg.sv
hw/rtl/vpbd_line_store.sv
hw/rtl/vpbd_window.sv
hw/rtl/valid_pixel_boundary_detect_top.sv
dv/valid_pixel_boundary_detect_top_tb.sv
